FILE: hdl/pnsc_pkg.sv
`default_nettype none
package pnsc_pkg;

   localparam int CAM_MAX_WIDTH  = 640;
   localparam int CAM_MAX_HEIGHT = 480;
   localparam int FRAME_MAX_DIM  = 4096;
   localparam int STORE_DEPTH    = CAM_MAX_WIDTH * CAM_MAX_HEIGHT;
   localparam int ADDR_W         = 19;
   localparam int QBITS          = 10;

   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_CAM_WIDTH    = 3'd2;
   localparam logic [2:0] CSR_CAM_HEIGHT   = 3'd3;
   localparam logic [2:0] CSR_MIX_MODE     = 3'd4;

   localparam logic [1:0] MODE_PASS    = 2'd0;
   localparam logic [1:0] MODE_OVERLAY = 2'd1;
   localparam logic [1:0] MODE_FULL    = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   typedef struct packed {
      logic        ready;
      logic [12:0] w;
      logic [12:0] h;
      logic [9:0]  cw;
      logic [8:0]  ch;
      logic [1:0]  mode;
      logic [12:0] ox;
      logic [12:0] oy;
      logic [12:0] ow;
      logic [12:0] oh;
   } geom_type;

   typedef struct packed {
      logic              valid;
      logic              load;
      logic              hit;
      logic [ADDR_W-1:0] addr;
      logic [23:0]       bgr;
      logic [31:0]       screen;
      logic [21:0]       ax;
      logic [21:0]       ay;
      logic [12:0]       dvx;
      logic [12:0]       dvy;
      logic [QBITS-1:0]  qx;
      logic [QBITS-1:0]  qy;
   } item_type;

endpackage
`default_nettype wire

FILE: hdl/pnsc_if.sv
`default_nettype none
interface pnsc_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [18:0] cam_index;
   logic [23:0] cam_bgr;
   logic [11:0] pos_x;
   logic [11:0] pos_y;
   logic [31:0] screen_bgra;
   modport source (output valid, op, cam_index, cam_bgr, pos_x, pos_y, screen_bgra,
                   input ready);
   modport sink (input valid, op, cam_index, cam_bgr, pos_x, pos_y, screen_bgra,
                 output ready);
endinterface

interface pnsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_bgra;
   logic        from_camera;
   modport source (output valid, out_bgra, from_camera, input ready);
   modport sink (input valid, out_bgra, from_camera, output ready);
endinterface
`default_nettype wire

FILE: hdl/pnsc_geom.sv
`default_nettype none
module pnsc_geom (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [12:0]       csr_wdata,
   output pnsc_pkg::geom_type     geom
);
   import pnsc_pkg::*;

   typedef enum logic [3:0] {
      ST_M_GO, ST_OH_GO, ST_OH_WAIT, ST_OW_GO, ST_OW_WAIT, ST_CLAMP, ST_POS, ST_DONE
   } state_type;

   logic [12:0] fw_ff, fh_ff;
   logic [9:0]  cwr_ff;
   logic [8:0]  chr_ff;
   logic [1:0]  mode_ff;
   state_type   state_ff;

   logic [19:0] dq_ff;
   logic [12:0] dr_ff;
   logic [12:0] dd_ff;
   logic [4:0]  dcnt_ff;

   logic [6:0]  m_ff;
   logic [10:0] moh_ff;
   logic [19:0] owp_ff, ohp_ff;
   logic [12:0] ow_ff, oh_ff, ox_ff, oy_ff;

   logic [12:0] w_eff, h_eff, min_wh;
   logic [9:0]  cw_eff;
   logic [8:0]  ch_eff;
   logic [10:0] ow0;
   logic [13:0] trial;
   logic [19:0] prod_oh, prod_ow;
   logic [25:0] m_prod, moh_prod;
   logic signed [14:0] lim_w, lim_h, pos_x, pos_y;

   function automatic logic [12:0] eff_dim(input logic [12:0] v);
      logic [12:0] d;
      d = v;
      if (v < 13'd2) d = 13'd2;
      if (v > 13'(FRAME_MAX_DIM)) d = 13'(FRAME_MAX_DIM);
      return {d[12:1], 1'b0};
   endfunction

   // max(2, min(v, lim)) with a possibly negative limit
   function automatic logic [12:0] clamp2(input logic [19:0] v,
                                          input logic signed [14:0] lim);
      logic [12:0] r;
      if (lim < 15'sd2) r = 13'd2;
      else if (v > 20'(lim)) r = lim[12:0];
      else if (v < 20'd2) r = 13'd2;
      else r = v[12:0];
      return r;
   endfunction

   always_comb begin
      w_eff  = eff_dim(fw_ff);
      h_eff  = eff_dim(fh_ff);
      min_wh = (w_eff < h_eff) ? w_eff : h_eff;
      cw_eff = (cwr_ff > 10'(CAM_MAX_WIDTH)) ? 10'(CAM_MAX_WIDTH) : cwr_ff;
      ch_eff = (chr_ff > 9'(CAM_MAX_HEIGHT)) ? 9'(CAM_MAX_HEIGHT) : chr_ff;
      ow0    = (w_eff[12:2] < 11'd2) ? 11'd2 : w_eff[12:2];
      trial  = {dr_ff, dq_ff[19]};
      prod_oh = 20'(ow0 * ch_eff);
      prod_ow = 20'(moh_ff * cw_eff);
      // Division by 60 and by 3 as reciprocal products, exact for sizes up to 4096.
      m_prod   = 26'(min_wh) * 26'd4370;
      moh_prod = 26'(h_eff) * 26'd2731;
      lim_w  = $signed({2'b0, w_eff}) - $signed({7'b0, m_ff, 1'b0});
      lim_h  = $signed({2'b0, h_eff}) - $signed({7'b0, m_ff, 1'b0});
      pos_x  = $signed({2'b0, w_eff}) - $signed({2'b0, ow_ff}) - $signed({8'b0, m_ff});
      pos_y  = $signed({2'b0, h_eff}) - $signed({2'b0, oh_ff}) - $signed({8'b0, m_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff    <= 13'd1920;
         fh_ff    <= 13'd1080;
         cwr_ff   <= 10'd640;
         chr_ff   <= 9'd480;
         mode_ff  <= MODE_PASS;
         state_ff <= ST_M_GO;
         dcnt_ff  <= '0;
      end else begin
         if ((dcnt_ff != 5'd0) && ((state_ff == ST_OH_WAIT) || (state_ff == ST_OW_WAIT))) begin
            if (trial >= {1'b0, dd_ff}) begin
               dr_ff <= 13'(trial - {1'b0, dd_ff});
               dq_ff <= {dq_ff[18:0], 1'b1};
            end else begin
               dr_ff <= trial[12:0];
               dq_ff <= {dq_ff[18:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 5'd1;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  fw_ff   <= csr_wdata;
               CSR_FRAME_HEIGHT: fh_ff   <= csr_wdata;
               CSR_CAM_WIDTH:    cwr_ff  <= csr_wdata[9:0];
               CSR_CAM_HEIGHT:   chr_ff  <= csr_wdata[8:0];
               CSR_MIX_MODE:     mode_ff <= csr_wdata[1:0];
               default: ;
            endcase
            state_ff <= ST_M_GO;
         end else begin
            case (state_ff)
               ST_M_GO: begin
                  m_ff   <= (m_prod[24:18] < 7'd16) ? 7'd16 : m_prod[24:18];
                  moh_ff <= (moh_prod[23:13] < 11'd2) ? 11'd2 : moh_prod[23:13];
                  state_ff <= ST_OH_GO;
               end
               ST_OH_GO: begin
                  dq_ff <= prod_oh; dd_ff <= {3'd0, cw_eff}; dr_ff <= '0; dcnt_ff <= 5'd20;
                  state_ff <= ST_OH_WAIT;
               end
               ST_OH_WAIT: begin
                  if (dcnt_ff == 5'd0) begin
                     if (dq_ff > {9'd0, moh_ff}) begin
                        ohp_ff   <= {9'd0, moh_ff};
                        state_ff <= ST_OW_GO;
                     end else begin
                        ohp_ff   <= dq_ff;
                        owp_ff   <= {9'd0, ow0};
                        state_ff <= ST_CLAMP;
                     end
                  end
               end
               ST_OW_GO: begin
                  dq_ff <= prod_ow; dd_ff <= {4'd0, ch_eff}; dr_ff <= '0; dcnt_ff <= 5'd20;
                  state_ff <= ST_OW_WAIT;
               end
               ST_OW_WAIT: begin
                  if (dcnt_ff == 5'd0) begin
                     owp_ff   <= dq_ff;
                     state_ff <= ST_CLAMP;
                  end
               end
               ST_CLAMP: begin
                  ow_ff    <= clamp2(owp_ff, lim_w);
                  oh_ff    <= clamp2(ohp_ff, lim_h);
                  state_ff <= ST_POS;
               end
               ST_POS: begin
                  ox_ff    <= (pos_x < 15'sd0) ? 13'd0 : pos_x[12:0];
                  oy_ff    <= (pos_y < 15'sd0) ? 13'd0 : pos_y[12:0];
                  state_ff <= ST_DONE;
               end
               ST_DONE: state_ff <= ST_DONE;
               default: state_ff <= ST_M_GO;
            endcase
         end
      end
   end

   always_comb begin
      geom.ready = (state_ff == ST_DONE);
      geom.w     = w_eff;
      geom.h     = h_eff;
      geom.cw    = cw_eff;
      geom.ch    = ch_eff;
      geom.mode  = mode_ff;
      geom.ox    = ox_ff;
      geom.oy    = oy_ff;
      geom.ow    = ow_ff;
      geom.oh    = oh_ff;
   end
endmodule
`default_nettype wire

FILE: hdl/pnsc_scale_pipe.sv
`default_nettype none
module pnsc_scale_pipe (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               accept,
   input  wire logic               op,
   input  wire logic [18:0]        cam_index,
   input  wire logic [23:0]        cam_bgr,
   input  wire logic [11:0]        pos_x,
   input  wire logic [11:0]        pos_y,
   input  wire logic [31:0]        screen_bgra,
   input  pnsc_pkg::geom_type      geom,
   output pnsc_pkg::item_type      mem_item
);
   import pnsc_pkg::*;

   localparam int LAST = QBITS + 2;

   item_type pipe_ff [0:LAST];
   item_type pipe_in [0:LAST];

   always_comb begin
      item_type    t;
      logic [22:0] dsx, dsy;
      logic [13:0] xe, ye;
      logic        in_frame, in_box, cam_ok;
      logic [19:0] lin;

      xe = {2'b0, pos_x};
      ye = {2'b0, pos_y};
      cam_ok   = (geom.cw != 10'd0) && (geom.ch != 9'd0);
      in_frame = (xe < {1'b0, geom.w}) && (ye < {1'b0, geom.h});
      in_box   = (xe >= {1'b0, geom.ox}) && (xe < ({1'b0, geom.ox} + {1'b0, geom.ow}))
              && (ye >= {1'b0, geom.oy}) && (ye < ({1'b0, geom.oy} + {1'b0, geom.oh}));

      t        = '0;
      t.valid  = accept;
      t.load   = (op == OP_LOAD);
      t.addr   = cam_index;
      t.bgr    = cam_bgr;
      t.screen = screen_bgra;
      t.hit    = (op == OP_PIXEL) && cam_ok && in_frame
              && ((geom.mode == MODE_FULL) || ((geom.mode == MODE_OVERLAY) && in_box));
      if (geom.mode == MODE_FULL) begin
         t.ax  = {10'd0, pos_x};
         t.ay  = {10'd0, pos_y};
         t.dvx = geom.w;
         t.dvy = geom.h;
      end else begin
         t.ax  = 22'(xe - {1'b0, geom.ox});
         t.ay  = 22'(ye - {1'b0, geom.oy});
         t.dvx = geom.ow;
         t.dvy = geom.oh;
      end
      pipe_in[0] = t;

      t = pipe_ff[0];
      t.ax = 22'(t.ax[11:0] * geom.cw);
      t.ay = 22'(t.ay[11:0] * geom.ch);
      pipe_in[1] = t;

      // Restoring division, one quotient bit per stage; quotients stay below 2^QBITS.
      for (int k = 0; k < QBITS; k++) begin
         t   = pipe_ff[1+k];
         dsx = {10'd0, t.dvx} << (QBITS - 1 - k);
         dsy = {10'd0, t.dvy} << (QBITS - 1 - k);
         if ({1'b0, t.ax} >= dsx) begin
            t.ax = t.ax - dsx[21:0];
            t.qx[QBITS-1-k] = 1'b1;
         end
         if ({1'b0, t.ay} >= dsy) begin
            t.ay = t.ay - dsy[21:0];
            t.qy[QBITS-1-k] = 1'b1;
         end
         pipe_in[2+k] = t;
      end

      t   = pipe_ff[LAST-1];
      lin = 20'(t.qy * geom.cw) + {10'd0, t.qx};
      if (!t.load) t.addr = lin[ADDR_W-1:0];
      pipe_in[LAST] = t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) pipe_ff[i].valid <= 1'b0;
      end else if (en) begin
         for (int i = 0; i <= LAST; i++) pipe_ff[i] <= pipe_in[i];
      end
   end

   assign mem_item = pipe_ff[LAST];
endmodule
`default_nettype wire

FILE: hdl/pnsc_store.sv
`default_nettype none
module pnsc_store (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic                       we,
   input  wire logic [pnsc_pkg::ADDR_W-1:0] addr,
   input  wire logic [23:0]                wdata,
   output logic [23:0]                     rdata
);
   import pnsc_pkg::*;

   logic [23:0] mem [0:STORE_DEPTH-1];
   logic [23:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) mem[addr] <= wdata;
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

FILE: hdl/pip_overlay_nearest_scaler_core.sv
`default_nettype none
// A screen pixel goes through the scale pipeline registers, then the store read register.
// Throughput: one transaction per cycle unless a result waits on rsp_ch.ready.
// Reset and every configuration write start a geometry recompute, plus a width division
// when the inset height limit applies; no transaction is accepted until it finishes.
// Reset is synchronous; the camera store is not cleared and holds undefined data.
module pip_overlay_nearest_scaler_core (
   input  wire logic        clock,
   input  wire logic        reset,
   pnsc_req_if.sink         req_ch,
   pnsc_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [12:0] csr_wdata
);
   import pnsc_pkg::*;

   geom_type    geom;
   item_type    mem_item;
   logic        en, accept, store_we;
   logic [23:0] rdata;
   logic        rsp_valid_ff, hit_ff;
   logic [31:0] screen_ff;

   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en && geom.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign store_we     = mem_item.valid && mem_item.load
                      && ({1'b0, mem_item.addr} < 20'(STORE_DEPTH));

   pnsc_geom u_geom (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata, .geom
   );

   pnsc_scale_pipe u_pipe (
      .clock, .reset, .en, .accept,
      .op(req_ch.op), .cam_index(req_ch.cam_index), .cam_bgr(req_ch.cam_bgr),
      .pos_x(req_ch.pos_x), .pos_y(req_ch.pos_y), .screen_bgra(req_ch.screen_bgra),
      .geom, .mem_item
   );

   pnsc_store u_store (
      .clock, .en, .we(store_we), .addr(mem_item.addr), .wdata(mem_item.bgr), .rdata
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= mem_item.valid && !mem_item.load;
         hit_ff       <= mem_item.hit;
         screen_ff    <= mem_item.screen;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_bgra    = hit_ff ? {8'hFF, rdata} : screen_ff;
   assign rsp_ch.from_camera = hit_ff;
endmodule
`default_nettype wire

FILE: verif/tb_pip_overlay_nearest_scaler_core.sv
`default_nettype none
module tb_pip_overlay_nearest_scaler_core;
   import pnsc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        op;
      logic [18:0] cam_index;
      logic [23:0] cam_bgr;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [31:0] screen_bgra;
   } pix_req_type;

   typedef struct {
      logic [31:0] out_bgra;
      logic        from_camera;
   } pix_rsp_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [12:0] csr_wdata;

   pnsc_req_if req_ch ();
   pnsc_rsp_if rsp_ch ();

   pip_overlay_nearest_scaler_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies; they only change while the block is idle.
   logic [12:0] cfg_fw, cfg_fh;
   logic [9:0]  cfg_cw;
   logic [8:0]  cfg_ch;
   logic [1:0]  cfg_mode;

   logic [23:0] cam_mem [int];     // camera store contents as the block sees them
   bit          staged_entry [int]; // entries whose load is already queued

   pix_req_type pending_q [$];
   pix_rsp_type expected_q [$];

   int errors = 0;
   int n_pixels = 0, n_hits = 0, n_loads = 0, n_phases = 0;
   int burst_left = 8, gap_left = 0;
   int hold_left = 0;
   bit hold_req = 0;
   int cyc = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint eff_dim(logic [12:0] v);
      longint d;
      d = (v < 2) ? 2 : v;
      if (d > FRAME_MAX_DIM) d = FRAME_MAX_DIM;
      return (d / 2) * 2;
   endfunction

   function automatic longint lmax(longint a, longint b);
      return a > b ? a : b;
   endfunction

   function automatic longint lmin(longint a, longint b);
      return a < b ? a : b;
   endfunction

   // Inset rectangle for the corner overlay under the current registers.
   function automatic void inset_geometry(output longint ox, output longint oy,
                                          output longint ow, output longint oh);
      longint W, H, cw, ch, m, moh;
      W   = eff_dim(cfg_fw);
      H   = eff_dim(cfg_fh);
      cw  = lmin(cfg_cw, CAM_MAX_WIDTH);
      ch  = lmin(cfg_ch, CAM_MAX_HEIGHT);
      m   = lmax(16, lmin(W, H) / 60);
      ow  = lmax(2, W / 4);
      oh  = ow * ch / cw;
      moh = lmax(2, H / 3);
      if (oh > moh) begin
         oh = moh;
         ow = oh * cw / ch;
      end
      ow = lmax(2, lmin(ow, W - 2 * m));
      oh = lmax(2, lmin(oh, H - 2 * m));
      ox = lmax(0, W - ow - m);
      oy = lmax(0, H - oh - m);
   endfunction

   // Returns the camera store index a screen pixel maps to, or -1 if it keeps its value.
   function automatic longint camera_index(logic [11:0] px, logic [11:0] py);
      longint W, H, cw, ch, x, y, ox, oy, ow, oh;
      W  = eff_dim(cfg_fw);
      H  = eff_dim(cfg_fh);
      cw = lmin(cfg_cw, CAM_MAX_WIDTH);
      ch = lmin(cfg_ch, CAM_MAX_HEIGHT);
      x  = px;
      y  = py;
      if (cw == 0 || ch == 0 || x >= W || y >= H) return -1;
      if (cfg_mode == MODE_FULL) return (y * ch / H) * cw + (x * cw / W);
      if (cfg_mode != MODE_OVERLAY) return -1;
      inset_geometry(ox, oy, ow, oh);
      if (x >= ox && x < ox + ow && y >= oy && y < oy + oh)
         return ((y - oy) * ch / oh) * cw + ((x - ox) * cw / ow);
      return -1;
   endfunction

   task automatic apply_transaction(pix_req_type it);
      pix_rsp_type r;
      longint      idx;
      if (it.op == OP_LOAD) begin
         if (it.cam_index < STORE_DEPTH) cam_mem[int'(it.cam_index)] = it.cam_bgr;
         n_loads++;
      end else begin
         idx = camera_index(it.pos_x, it.pos_y);
         if (idx >= 0) begin
            r.out_bgra    = {8'hFF, cam_mem[int'(idx)]};
            r.from_camera = 1'b1;
            n_hits++;
         end else begin
            r.out_bgra    = it.screen_bgra;
            r.from_camera = 1'b0;
         end
         expected_q.push_back(r);
         n_pixels++;
      end
   endtask

   task automatic queue_load(logic [18:0] idx, logic [23:0] bgr);
      pix_req_type it;
      it = '{op: OP_LOAD, cam_index: idx, cam_bgr: bgr, pos_x: 12'($urandom),
             pos_y: 12'($urandom), screen_bgra: $urandom};
      if (idx < STORE_DEPTH) staged_entry[int'(idx)] = 1;
      pending_q.push_back(it);
   endtask

   // Queues a screen pixel, first loading the store entry it reads if that is still empty.
   task automatic queue_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] scr);
      pix_req_type it;
      longint      idx;
      idx = camera_index(x, y);
      if (idx >= 0 && !staged_entry.exists(int'(idx))) queue_load(idx[18:0], 24'($urandom));
      it = '{op: OP_PIXEL, cam_index: 19'($urandom), cam_bgr: 24'($urandom), pos_x: x,
             pos_y: y, screen_bgra: scr};
      pending_q.push_back(it);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [12:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic configure(int fw, int fh, int cw, int ch, logic [1:0] mode);
      wait (pending_q.size() == 0 && expected_q.size() == 0);
      // A trailing load may still be in flight after the last result.
      repeat (20) @(posedge clock);
      write_csr(CSR_FRAME_WIDTH, 13'(fw));
      write_csr(CSR_FRAME_HEIGHT, 13'(fh));
      write_csr(CSR_CAM_WIDTH, 13'(cw));
      write_csr(CSR_CAM_HEIGHT, 13'(ch));
      write_csr(CSR_MIX_MODE, 13'(mode));
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_fw   = 13'(fw);
      cfg_fh   = 13'(fh);
      cfg_cw   = 10'(cw);
      cfg_ch   = 9'(ch);
      cfg_mode = mode;
      n_phases++;
   endtask

   task automatic random_phase(int count, bit with_hold);
      longint W, H, ox, oy, ow, oh;
      int     r;
      logic [11:0] x, y;
      W = eff_dim(cfg_fw);
      H = eff_dim(cfg_fh);
      ox = 0; oy = 0; ow = W; oh = H;
      if (cfg_mode == MODE_OVERLAY && cfg_cw != 0 && cfg_ch != 0)
         inset_geometry(ox, oy, ow, oh);
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 3) hold_req = 1;
         r = $urandom_range(0, 19);
         if (r < 2) begin
            queue_load(19'($urandom), 24'($urandom));
            continue;
         end
         if (r < 12) begin
            x = 12'(ox + $urandom_range(0, ow - 1));
            y = 12'(oy + $urandom_range(0, oh - 1));
         end else if (r < 17) begin
            x = 12'($urandom_range(0, W - 1));
            y = 12'($urandom_range(0, H - 1));
         end else begin
            x = 12'($urandom);
            y = 12'($urandom);
         end
         queue_pixel(x, y, $urandom);
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!(req_ch.valid && !req_ch.ready)) begin
         if (req_ch.valid) begin
            apply_transaction(pending_q[0]);
            void'(pending_q.pop_front());
         end
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            req_ch.valid       <= 1'b1;
            req_ch.op          <= pending_q[0].op;
            req_ch.cam_index   <= pending_q[0].cam_index;
            req_ch.cam_bgr     <= pending_q[0].cam_bgr;
            req_ch.pos_x       <= pending_q[0].pos_x;
            req_ch.pos_y       <= pending_q[0].pos_y;
            req_ch.screen_bgra <= pending_q[0].screen_bgra;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: alternating stretches of free flow and random stalls, plus a long hold in each phase that asks for one.
   always @(posedge clock) begin
      cyc++;
      if (hold_req) begin
         hold_req  = 0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if ((cyc / 150) % 3 == 0) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      pix_rsp_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result out_bgra=%h from_camera=%b", $realtime,
                     rsp_ch.out_bgra, rsp_ch.from_camera);
         end else begin
            e = expected_q.pop_front();
            if (rsp_ch.out_bgra !== e.out_bgra) begin
               errors++;
               $display("%0t: out_bgra expected %h actual %h", $realtime, e.out_bgra,
                        rsp_ch.out_bgra);
            end
            if (rsp_ch.from_camera !== e.from_camera) begin
               errors++;
               $display("%0t: from_camera expected %b actual %b", $realtime,
                        e.from_camera, rsp_ch.from_camera);
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("tb_pip_overlay_nearest_scaler_core failed");
      $finish;
   end

   initial begin
      int drain;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_FRAME_WIDTH;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.op          = OP_LOAD;
      req_ch.cam_index   = '0;
      req_ch.cam_bgr     = '0;
      req_ch.pos_x       = '0;
      req_ch.pos_y       = '0;
      req_ch.screen_bgra = '0;
      rsp_ch.ready       = 1'b0;
      cfg_fw = 1920; cfg_fh = 1080; cfg_cw = 640; cfg_ch = 480; cfg_mode = MODE_PASS;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes of the store index and of the pixel fields.
      queue_pixel(12'd0, 12'd0, 32'h0);
      queue_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
      configure(1920, 1080, 640, 480, MODE_FULL);
      queue_load(19'd0, 24'hFFFFFF);
      queue_load(19'd307199, 24'h000000);
      queue_load(19'h7FFFF, 24'hA5A5A5);   // beyond the store, dropped
      queue_pixel(12'd0, 12'd0, 32'h1234_5678);
      queue_pixel(12'd1919, 12'd1079, 32'h0);
      queue_pixel(12'd1920, 12'd5, 32'hDEAD_BEEF);
      queue_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
      configure(1920, 1080, 640, 480, MODE_OVERLAY);
      queue_pixel(12'd1900, 12'd1060, 32'h0);
      queue_pixel(12'd1919, 12'd1079, 32'h5555_AAAA);
      queue_pixel(12'd0, 12'd0, 32'hAAAA_5555);
      configure(8191, 8191, 1023, 511, MODE_FULL);  // all sizes saturate
      queue_pixel(12'd4095, 12'd4095, 32'h0);
      queue_pixel(12'd4094, 12'd0, 32'hFFFF_FFFF);
      configure(0, 1, 1, 1, MODE_FULL);             // frame rounds up to two
      queue_pixel(12'd1, 12'd1, 32'h0);
      queue_pixel(12'd2, 12'd0, 32'h0);
      configure(1920, 1080, 0, 480, MODE_OVERLAY);  // no camera picture
      queue_pixel(12'd1900, 12'd1060, 32'h0F0F_0F0F);
      configure(1920, 1080, 640, 480, 2'd3);        // mode three passes through
      queue_pixel(12'd10, 12'd10, 32'hF0F0_F0F0);

      // Random phases over a spread of geometries.
      configure(1920, 1080, 640, 480, MODE_OVERLAY);
      random_phase(110, 1);
      configure(101, 77, 7, 5, MODE_OVERLAY);
      random_phase(90, 0);
      configure(64, 48, 3, 200, MODE_OVERLAY);
      random_phase(90, 0);
      configure(8191, 8191, 1023, 511, MODE_OVERLAY);
      random_phase(90, 0);
      configure(2, 2, 1, 1, MODE_OVERLAY);
      random_phase(40, 0);
      configure(4096, 4096, 640, 480, MODE_FULL);
      random_phase(90, 0);
      configure(33, 17, 12, 9, MODE_FULL);
      random_phase(90, 0);
      configure(640, 480, 640, 480, MODE_PASS);
      random_phase(60, 0);
      configure(1280, 720, 0, 0, MODE_FULL);
      random_phase(40, 0);
      configure(1280, 720, 320, 240, 2'd3);
      random_phase(40, 0);
      configure($urandom_range(2, 4096), $urandom_range(2, 4096), $urandom_range(1, 64),
                $urandom_range(1, 64), MODE_OVERLAY);
      random_phase(90, 1);

      wait (pending_q.size() == 0 && expected_q.size() == 0);
      drain = 0;
      while (drain < 40) begin
         @(posedge clock);
         drain++;
      end
      $display("Covered %0d screen pixels (%0d from the camera store) and %0d loads",
               n_pixels, n_hits, n_loads);
      $display("over %0d register settings in pass, overlay and full modes.", n_phases);
      if (errors == 0) begin
         $display("tb_pip_overlay_nearest_scaler_core passed");
      end else begin
         $display("tb_pip_overlay_nearest_scaler_core failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
hdl/pnsc_pkg.sv
hdl/pnsc_if.sv
hdl/pnsc_geom.sv
hdl/pnsc_scale_pipe.sv
hdl/pnsc_store.sv
hdl/pip_overlay_nearest_scaler_core.sv
verif/tb_pip_overlay_nearest_scaler_core.sv
